>>> design/prq_pkg.sv
// Package for the priority bitmap ready queue: sizes, operation and register
// codes, the command passed from front to back, and the top-level finder.
// No dependencies.
package prq_pkg;

  localparam int MAX_THREADS = 32;
  localparam int PRIO_LEVELS = 32;
  localparam int TID_W       = $clog2(MAX_THREADS);
  localparam int PRIO_W      = $clog2(PRIO_LEVELS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int OP_W        = 2;

  // Command queue between front and back, depth a power of two.
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_FIFO_PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_FIFO_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  // APB register map: two 32-bit registers at byte addresses 0 and 4.
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_LOCKED  = 1'b0;
  localparam logic REG_STARTED = 1'b1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHED  = 2'd2;
  localparam logic [OP_W-1:0] OP_FORCE  = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ADD,
    CMD_REMOVE,
    CMD_SCHED
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic              empty;
    logic [PRIO_W-1:0] level;
  } top_t;

  // Lowest set bit of the level bitmap; empty when no bit is set.
  function automatic top_t find_top(input logic [PRIO_LEVELS-1:0] map);
    top_t r;
    r.empty = 1'b1;
    r.level = '0;
    for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
      if (map[i]) begin
        r.empty = 1'b0;
        r.level = PRIO_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> design/prq_if.sv
// Valid/ready channel interfaces for the ready queue: request items in,
// result items out. Depends on prq_pkg.
interface prq_in_if;
  logic                            valid;
  logic                            ready;
  logic [prq_pkg::OP_W-1:0]        operation;
  logic [prq_pkg::TID_W-1:0]       thread_id;
  logic [prq_pkg::PRIO_W-1:0]      prio;
  logic                            in_interrupt;

  modport source (output valid, operation, thread_id, prio, in_interrupt, input ready);
  modport sink   (input valid, operation, thread_id, prio, in_interrupt, output ready);
endinterface

interface prq_out_if;
  logic                            valid;
  logic                            ready;
  logic [prq_pkg::TID_W-1:0]       selected_thread;
  logic                            switched;
  logic                            queue_empty;
  logic [prq_pkg::CNT_W-1:0]       ready_total;
  logic [prq_pkg::TID_W-1:0]       running_now;

  modport source (output valid, selected_thread, switched, queue_empty, ready_total,
                  running_now, input ready);
  modport sink   (input valid, selected_thread, switched, queue_empty, ready_total,
                  running_now, output ready);
endinterface

>>> design/priority_bitmap_ready_queue_core.sv
// Top level of the priority bitmap ready queue: APB control registers,
// front end, command queue and back end. Depends on prq_pkg, prq_if.
//
// Usage:
//   in_i  : request items (operation, thread_id, prio, in_interrupt) on a
//           valid/ready channel. Add, remove, gated schedule, forced select.
//   out_o : one result item per request (selected_thread, switched,
//           queue_empty, ready_total, running_now), valid/ready channel.
//   APB   : register 0 sched_locked (addr 0, reset 1), register 1
//           sched_started (addr 4, reset 0), bit 0 of pwdata. pready is tied
//           high; reads return the register in bit 0.
// Steps: the front captures an item, then checks it against the per-thread
//   queued bits and level memory, and takes no new item until it has
//   issued the command. The back reads the head/tail/link memories, updates
//   them and the bitmap, then reads the new top head for the result; it
//   takes the next command only once the last result has been registered.
// Reset: bitmap, ready count, running thread and need_schedule clear; the
//   link memories are not cleared and need no pass, queued bits guard them.
// Stall: a result waits in the output register; the back holds the next one,
//   the command queue fills, and then the front drops in_i.ready.
module priority_bitmap_ready_queue_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prq_in_if.sink                        in_i,
  prq_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prq_pkg::APB_AW-1:0]    paddr,
  input  logic [prq_pkg::APB_DW-1:0]    pwdata,
  output logic [prq_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic          locked_q, started_q;
  logic          apb_wr;
  logic          reg_sel;
  prq_pkg::cmd_t front_cmd, back_cmd;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;

  // Control registers: to be written by the user only while the block is idle; the block does not enforce it.
  assign pready  = 1'b1;
  assign reg_sel = paddr[prq_pkg::REG_IDX_LSB];
  assign apb_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q  <= 1'b1;
      started_q <= 1'b0;
    end else if (apb_wr) begin
      unique case (reg_sel)
        prq_pkg::REG_LOCKED:  locked_q  <= pwdata[0];
        prq_pkg::REG_STARTED: started_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      prq_pkg::REG_LOCKED:  prdata[0] = locked_q;
      prq_pkg::REG_STARTED: prdata[0] = started_q;
      default: ;
    endcase
  end

  // Front: validity checks and need_schedule gating.
  prq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .locked_i  (locked_q),
    .started_i (started_q),
    .cmd_o     (front_cmd),
    .push_o    (cmd_push),
    .full_i    (cmd_full)
  );

  // Decouples the front from a stalled back end.
  prq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // Back: list maintenance, schedule and result register.
  prq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (back_cmd),
    .empty_i (cmd_empty),
    .pop_o   (cmd_pop),
    .out_o   (out_o)
  );

endmodule

>>> design/prq_front.sv
// Front end: accepts request items, checks them against the queued bits and
// levels, tracks need_schedule and issues commands. Depends on prq_pkg, prq_if.
module prq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  prq_in_if.sink          in_i,
  input  logic            locked_i,
  input  logic            started_i,
  output prq_pkg::cmd_t   cmd_o,
  output logic            push_o,
  input  logic            full_i
);

  localparam logic F_IDLE  = 1'b0;
  localparam logic F_CLASS = 1'b1;

  logic                              state_q, state_d;
  logic [prq_pkg::OP_W-1:0]          op_q;
  logic [prq_pkg::TID_W-1:0]         tid_q;
  logic [prq_pkg::PRIO_W-1:0]        prio_q;
  logic                              intr_q;
  logic [prq_pkg::MAX_THREADS-1:0]   queued_q, queued_d;
  logic                              need_q, need_d;
  logic [prq_pkg::PRIO_W-1:0]        qlevel_mem [prq_pkg::MAX_THREADS];
  logic [prq_pkg::PRIO_W-1:0]        qlvl_rd_q;
  logic                              qlvl_we;
  logic                              accept;

  assign in_i.ready = (state_q == F_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d   = state_q;
    queued_d  = queued_q;
    need_d    = need_q;
    qlvl_we   = 1'b0;
    push_o    = 1'b0;
    cmd_o.op    = prq_pkg::CMD_NOP;
    cmd_o.tid   = tid_q;
    cmd_o.level = prio_q;

    unique case (op_q)
      prq_pkg::OP_ADD: begin
        if (!queued_q[tid_q]) cmd_o.op = prq_pkg::CMD_ADD;
      end
      prq_pkg::OP_REMOVE: begin
        if (queued_q[tid_q] && qlvl_rd_q == prio_q) cmd_o.op = prq_pkg::CMD_REMOVE;
      end
      prq_pkg::OP_SCHED: begin
        if (need_q && !intr_q && !locked_i && started_i) cmd_o.op = prq_pkg::CMD_SCHED;
      end
      prq_pkg::OP_FORCE: begin
        cmd_o.op = prq_pkg::CMD_SCHED;
      end
      default: cmd_o.op = prq_pkg::CMD_NOP;
    endcase

    unique case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_CLASS;
      end
      F_CLASS: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
          case (cmd_o.op)
            prq_pkg::CMD_ADD: begin
              queued_d[tid_q] = 1'b1;
              qlvl_we         = 1'b1;
              need_d          = 1'b1;
            end
            prq_pkg::CMD_REMOVE: begin
              queued_d[tid_q] = 1'b0;
              need_d          = 1'b1;
            end
            prq_pkg::CMD_SCHED: need_d = 1'b0;
            default: ;
          endcase
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      queued_q <= '0;
      need_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      queued_q <= queued_d;
      need_q   <= need_d;
    end
  end

  // Item capture and the per-thread level memory.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_i.operation;
      tid_q     <= in_i.thread_id;
      prio_q    <= in_i.prio;
      intr_q    <= in_i.in_interrupt;
      qlvl_rd_q <= qlevel_mem[in_i.thread_id];
    end
    if (qlvl_we) qlevel_mem[tid_q] <= prio_q;
  end

endmodule

>>> design/prq_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on prq_pkg.
module prq_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  prq_pkg::cmd_t   data_i,
  output logic            full_o,
  input  logic            pop_i,
  output prq_pkg::cmd_t   data_o,
  output logic            empty_o
);

  prq_pkg::cmd_t                        mem_q [prq_pkg::CMD_FIFO_DEPTH];
  logic [prq_pkg::CMD_FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [prq_pkg::CMD_FIFO_CNT_W-1:0]   count_q;
  logic                                 do_push, do_pop;

  assign full_o  = (count_q == prq_pkg::CMD_FIFO_CNT_W'(prq_pkg::CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> design/prq_back.sv
// Back end: level bitmap, head/tail and link memories, running thread and
// the result register. Depends on prq_pkg, prq_if.
module prq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prq_pkg::cmd_t   cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  prq_out_if.source       out_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EXEC = 2'd1;
  localparam logic [1:0] B_RES  = 2'd2;

  localparam int TW = prq_pkg::TID_W;
  localparam int PW = prq_pkg::PRIO_W;

  logic [1:0]                        state_q, state_d;
  prq_pkg::cmd_t                     cmd_q;
  logic [prq_pkg::PRIO_LEVELS-1:0]   bitmap_q, bitmap_d;
  logic [prq_pkg::CNT_W-1:0]         count_q, count_d;
  logic [TW-1:0]                     running_q, running_d;
  logic                              sw_q, sw_d;
  logic                              fwd_q, fwd_d;
  logic [TW-1:0]                     fwd_data_q;

  logic [TW-1:0] head_mem [prq_pkg::PRIO_LEVELS];
  logic [TW-1:0] tail_mem [prq_pkg::PRIO_LEVELS];
  logic [TW-1:0] next_mem [prq_pkg::MAX_THREADS];
  logic [TW-1:0] prev_mem [prq_pkg::MAX_THREADS];
  logic [TW-1:0] head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;

  logic          head_we, tail_we, next_we, prev_we;
  logic [PW-1:0] head_wa, tail_wa, head_ra;
  logic [TW-1:0] next_wa, prev_wa;
  logic [TW-1:0] head_wd, tail_wd, next_wd, prev_wd;

  prq_pkg::top_t top_cur, top_nxt;
  logic          busy, at_head, at_tail, out_free, load_out;
  logic          out_valid_q;
  logic [TW-1:0] sel_thread;

  assign top_cur  = prq_pkg::find_top(bitmap_q);
  assign busy     = bitmap_q[cmd_q.level];
  assign at_head  = (head_rd_q == cmd_q.tid);
  assign at_tail  = (tail_rd_q == cmd_q.tid);
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_free = !out_valid_q || out_o.ready;
  assign load_out = (state_q == B_RES) && out_free;
  assign sel_thread = fwd_q ? fwd_data_q : head_rd_q;

  always_comb begin
    bitmap_d  = bitmap_q;
    count_d   = count_q;
    running_d = running_q;
    sw_d      = sw_q;
    head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
    head_wa = cmd_q.level; tail_wa = cmd_q.level;
    next_wa = tail_rd_q;   prev_wa = cmd_q.tid;
    head_wd = cmd_q.tid;   tail_wd = cmd_q.tid;
    next_wd = cmd_q.tid;   prev_wd = tail_rd_q;

    if (state_q == B_EXEC) begin
      sw_d = 1'b0;
      unique case (cmd_q.op)
        prq_pkg::CMD_ADD: begin
          // append at tail; the tail's next and the head's prev are never read
          tail_we = 1'b1;
          if (busy) begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end else begin
            head_we = 1'b1;
          end
          bitmap_d[cmd_q.level] = 1'b1;
          count_d = count_q + 1'b1;
        end
        prq_pkg::CMD_REMOVE: begin
          if (at_head && at_tail) begin
            bitmap_d[cmd_q.level] = 1'b0;
          end else if (at_head) begin
            head_we = 1'b1;
            head_wd = next_rd_q;
          end else if (at_tail) begin
            tail_we = 1'b1;
            tail_wd = prev_rd_q;
          end else begin
            next_we = 1'b1;
            next_wa = prev_rd_q;
            next_wd = next_rd_q;
            prev_we = 1'b1;
            prev_wa = next_rd_q;
            prev_wd = prev_rd_q;
          end
          if (count_q != '0) count_d = count_q - 1'b1;
        end
        prq_pkg::CMD_SCHED: begin
          if (!top_cur.empty && head_rd_q != running_q) begin
            running_d = head_rd_q;
            sw_d      = 1'b1;
          end
        end
        prq_pkg::CMD_NOP: ;
        default: ;
      endcase
    end

    top_nxt = prq_pkg::find_top(bitmap_d);
    // EXEC reads the new top head for the result and RES keeps rereading it
    // while the result waits; IDLE reads for the command
    if (state_q == B_EXEC)                   head_ra = top_nxt.level;
    else if (state_q == B_RES)               head_ra = top_cur.level;
    else if (cmd_i.op == prq_pkg::CMD_SCHED) head_ra = top_cur.level;
    else                                     head_ra = cmd_i.level;
    fwd_d = head_we && (head_wa == head_ra);

    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (pop_o) state_d = B_EXEC;
      B_EXEC:  state_d = B_RES;
      B_RES:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      bitmap_q    <= '0;
      count_q     <= '0;
      running_q   <= '0;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bitmap_q  <= bitmap_d;
      count_q   <= count_d;
      running_q <= running_d;
      sw_q      <= sw_d;
      if (load_out)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (pop_o)   tail_rd_q <= tail_mem[cmd_i.level];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (pop_o)   next_rd_q <= next_mem[cmd_i.tid];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (pop_o)   prev_rd_q <= prev_mem[cmd_i.tid];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    fwd_q      <= fwd_d;
    fwd_data_q <= head_wd;
    if (load_out) begin
      out_o.selected_thread <= top_cur.empty ? '0 : sel_thread;
      out_o.switched        <= sw_q;
      out_o.queue_empty     <= top_cur.empty;
      out_o.ready_total     <= count_q;
      out_o.running_now     <= running_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= prq_pkg::CNT_W'(prq_pkg::MAX_THREADS))
    else $error("ready count above thread count");

  a_bitmap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bitmap_q == '0) == (count_q == '0))
    else $error("level bitmap disagrees with ready count");

  a_switch_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.switched) |->
      (out_o.running_now == out_o.selected_thread) && !out_o.queue_empty)
    else $error("switch result does not point at queue head");

endmodule

>>> verif/priority_bitmap_ready_queue_core_tb.sv
// Self-checking testbench for priority_bitmap_ready_queue_core: random-gap driver,
// stalling result monitor, APB register writes between phases, in-bench scheduler model.
// Depends on prq_pkg and prq_if (design folder).
module priority_bitmap_ready_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_REPORTS   = 100;

  // Byte addresses of the two control registers.
  localparam logic [APB_AW-1:0] LOCKED_ADDR  = APB_AW'(REG_LOCKED) << REG_IDX_LSB;
  localparam logic [APB_AW-1:0] STARTED_ADDR = APB_AW'(REG_STARTED) << REG_IDX_LSB;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] lvl;
    logic              irq;
  } sched_req_t;

  typedef struct packed {
    logic [TID_W-1:0] sel;
    logic             switched;
    logic             empty;
    logic [CNT_W-1:0] total;
    logic [TID_W-1:0] running;
  } sched_rsp_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  prq_in_if  req_if ();
  prq_out_if rsp_if ();

  priority_bitmap_ready_queue_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Ready queue model. Mirrors the block's architectural state: level bitmap,
  // per-level head/tail, per-thread links, queued flag and level, count,
  // need_schedule flag, running thread, and the two control bits.
  // ---------------------------------------------------------------------------
  logic [PRIO_LEVELS-1:0] rq_map;
  logic [TID_W-1:0]       rq_head  [PRIO_LEVELS];
  logic [TID_W-1:0]       rq_tail  [PRIO_LEVELS];
  logic [TID_W-1:0]       rq_next  [MAX_THREADS];
  logic [TID_W-1:0]       rq_prev  [MAX_THREADS];
  logic                   rq_queued[MAX_THREADS];
  logic [PRIO_W-1:0]      rq_level [MAX_THREADS];
  logic [CNT_W-1:0]       rq_count;
  logic                   rq_need;
  logic [TID_W-1:0]       rq_running;
  logic                   cfg_locked;
  logic                   cfg_started;

  // Highest-priority (lowest-numbered) busy level.
  function automatic void rq_top(output logic found, output logic [PRIO_W-1:0] lvl);
    found = 1'b0;
    lvl   = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (!found && rq_map[i]) begin
        found = 1'b1;
        lvl   = PRIO_W'(i);
      end
    end
  endfunction

  // A schedule that actually runs: clears need, picks top head, flags a change.
  function automatic logic rq_dispatch();
    logic              found;
    logic [PRIO_W-1:0] lvl;
    rq_need = 1'b0;
    rq_top(found, lvl);
    if (found && rq_head[lvl] != rq_running) begin
      rq_running = rq_head[lvl];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic sched_rsp_t ready_queue_apply(input sched_req_t r);
    sched_rsp_t        o;
    logic              found;
    logic [PRIO_W-1:0] lvl;
    logic              at_head;
    logic              at_tail;
    logic [TID_W-1:0]  nx;
    logic [TID_W-1:0]  pv;
    o = '0;
    case (r.op)
      OP_ADD: begin
        // A thread already queued is left where it is.
        if (!rq_queued[r.tid]) begin
          if (rq_map[r.lvl]) begin
            rq_next[rq_tail[r.lvl]] = r.tid;
            rq_prev[r.tid]          = rq_tail[r.lvl];
          end else begin
            rq_head[r.lvl] = r.tid;
            rq_prev[r.tid] = r.tid;
          end
          rq_next[r.tid]   = r.tid;
          rq_tail[r.lvl]   = r.tid;
          rq_map[r.lvl]    = 1'b1;
          rq_queued[r.tid] = 1'b1;
          rq_level[r.tid]  = r.lvl;
          rq_count         = rq_count + 1'b1;
          rq_need          = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Unqueued thread or a level that does not match: no effect.
        if (rq_queued[r.tid] && rq_level[r.tid] == r.lvl) begin
          at_head = (rq_head[r.lvl] == r.tid);
          at_tail = (rq_tail[r.lvl] == r.tid);
          nx      = rq_next[r.tid];
          pv      = rq_prev[r.tid];
          if (at_head && at_tail) begin
            rq_map[r.lvl] = 1'b0;
          end else if (at_head) begin
            rq_head[r.lvl] = nx;
          end else if (at_tail) begin
            rq_tail[r.lvl] = pv;
          end else begin
            rq_next[pv] = nx;
            rq_prev[nx] = pv;
          end
          rq_queued[r.tid] = 1'b0;
          if (rq_count != '0) rq_count = rq_count - 1'b1;
          rq_need = 1'b1;
        end
      end
      OP_SCHED: begin
        // Gated: needs a pending change, no interrupt, unlocked and started.
        if (rq_need && !r.irq && !cfg_locked && cfg_started) o.switched = rq_dispatch();
      end
      default: begin
        o.switched = rq_dispatch();
      end
    endcase
    rq_top(found, lvl);
    o.sel     = found ? rq_head[lvl] : '0;
    o.empty   = !found;
    o.total   = rq_count;
    o.running = rq_running;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side. ops_to_send feeds the driver; the gen_* arrays track which
  // threads will be queued once everything already generated has been applied,
  // so random removes mostly hit real list entries (head, middle, tail).
  // ---------------------------------------------------------------------------
  sched_req_t        ops_to_send[$];
  sched_rsp_t        sched_outcomes_due[$];
  logic              gen_queued[MAX_THREADS];
  logic [PRIO_W-1:0] gen_level [MAX_THREADS];
  int                err_count;

  task automatic queue_item(input logic [OP_W-1:0] op, input int tid, input int lvl,
                            input logic irq);
    sched_req_t it;
    it.op  = op;
    it.tid = TID_W'(tid);
    it.lvl = PRIO_W'(lvl);
    it.irq = irq;
    if (op == OP_ADD && !gen_queued[it.tid]) begin
      gen_queued[it.tid] = 1'b1;
      gen_level[it.tid]  = it.lvl;
    end else if (op == OP_REMOVE && gen_queued[it.tid] && gen_level[it.tid] == it.lvl) begin
      gen_queued[it.tid] = 1'b0;
    end
    ops_to_send.push_back(it);
  endtask

  // Random thread in the wanted queued state, or -1 if there is none.
  function automatic int pick_thread(input logic want_queued);
    int start;
    int idx;
    start = $urandom_range(MAX_THREADS - 1);
    for (int k = 0; k < MAX_THREADS; k++) begin
      idx = (start + k) % MAX_THREADS;
      if (gen_queued[idx] == want_queued) return idx;
    end
    return -1;
  endfunction

  // add_w / rem_w are percentages; the rest splits between gated and forced.
  task automatic gen_random(input int n, input int add_w, input int rem_w);
    int r;
    int t;
    int lvl;
    logic irq;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      irq = 1'($urandom_range(1));
      t   = $urandom_range(MAX_THREADS - 1);
      lvl = $urandom_range(PRIO_LEVELS - 1);
      if (r < add_w) begin
        // Mostly fresh threads, often on a few levels so lists grow long.
        if ($urandom_range(99) < 85 && pick_thread(1'b0) >= 0) t = pick_thread(1'b0);
        if ($urandom_range(1) == 0) lvl = $urandom_range(3);
        queue_item(OP_ADD, t, lvl, irq);
      end else if (r < add_w + rem_w) begin
        r = $urandom_range(99);
        if (r < 90 && pick_thread(1'b1) >= 0) begin
          t   = pick_thread(1'b1);
          lvl = gen_level[t];
          // Some removes name the wrong level and must be ignored.
          if (r >= 80) lvl = int'(PRIO_W'(lvl + 1 + $urandom_range(PRIO_LEVELS - 2)));
        end
        queue_item(OP_REMOVE, t, lvl, irq);
      end else if (r < add_w + rem_w + (100 - add_w - rem_w) * 6 / 10) begin
        queue_item(OP_SCHED, t, lvl, $urandom_range(3) == 0);
      end else begin
        queue_item(OP_FORCE, t, lvl, irq);
      end
    end
  endtask

  // Every report counts; printing stops after a while to keep the log short.
  task automatic flag_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps (gaps of zero
  // give long back-to-back stretches). Valid holds its item until accepted;
  // the model is advanced at the accepting edge.
  // ---------------------------------------------------------------------------
  int burst_left = 10;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni && !(req_if.valid && !req_if.ready)) begin
      if (req_if.valid) begin
        sched_outcomes_due.push_back(ready_queue_apply(ops_to_send.pop_front()));
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left != 0 || ops_to_send.size() == 0) begin
        req_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        req_if.valid        <= 1'b1;
        req_if.operation    <= ops_to_send[0].op;
        req_if.thread_id    <= ops_to_send[0].tid;
        req_if.prio         <= ops_to_send[0].lvl;
        req_if.in_interrupt <= ops_to_send[0].irq;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: ready follows a rotating 8-bit pattern that is redrawn at random
  // (sometimes all ones, so no stall at all). Each accepted result is
  // checked field by field against the oldest expectation.
  // ---------------------------------------------------------------------------
  logic [7:0] stall_pat  = 8'hFF;
  int         stall_tick = 0;
  sched_rsp_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (sched_outcomes_due.size() == 0) begin
          flag_mismatch("result item with no request outstanding");
        end else begin
          want = sched_outcomes_due.pop_front();
          if (rsp_if.selected_thread !== want.sel)
            flag_mismatch($sformatf("selected_thread %0d, want %0d",
                                    rsp_if.selected_thread, want.sel));
          if (rsp_if.switched !== want.switched)
            flag_mismatch($sformatf("switched %b, want %b", rsp_if.switched, want.switched));
          if (rsp_if.queue_empty !== want.empty)
            flag_mismatch($sformatf("queue_empty %b, want %b", rsp_if.queue_empty, want.empty));
          if (rsp_if.ready_total !== want.total)
            flag_mismatch($sformatf("ready_total %0d, want %0d", rsp_if.ready_total, want.total));
          if (rsp_if.running_now !== want.running)
            flag_mismatch($sformatf("running_now %0d, want %0d",
                                    rsp_if.running_now, want.running));
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0)
        stall_pat = ($urandom_range(3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
      else
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      rsp_if.ready <= stall_pat[0];
    end
  end

  // Watchdog.
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // APB access. Write: setup, access (register written at the access edge),
  // then a read back of the same register, checked on bit 0.
  // ---------------------------------------------------------------------------
  task automatic apb_set(input logic [APB_AW-1:0] addr, input logic val);
    logic got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == LOCKED_ADDR) cfg_locked = val;
    else cfg_started = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== val)
      flag_mismatch($sformatf("register at 0x%0h reads %b, want %b", addr, got, val));
  endtask

  // Block is idle once nothing is queued, offered, or outstanding.
  task automatic wait_drained();
    while (ops_to_send.size() != 0 || sched_outcomes_due.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases.
  // ---------------------------------------------------------------------------
  initial begin
    // Known values on every input from time zero.
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_ADD;
    req_if.thread_id    = '0;
    req_if.prio         = '0;
    req_if.in_interrupt = 1'b0;
    rsp_if.ready        = 1'b1;
    err_count           = 0;

    // Model reset state; the control bits come up locked and not started.
    rq_map      = '0;
    rq_count    = '0;
    rq_need     = 1'b0;
    rq_running  = '0;
    cfg_locked  = 1'b1;
    cfg_started = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      rq_queued[i]  = 1'b0;
      rq_level[i]   = '0;
      gen_queued[i] = 1'b0;
      gen_level[i]  = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset configuration (locked, not started).
    queue_item(OP_FORCE,  31, 31, 1'b1); // forced select on an empty queue
    queue_item(OP_ADD,    31, 31, 1'b0); // lowest-priority level, top thread id
    queue_item(OP_FORCE,   0,  0, 1'b0); // switch to thread 31
    queue_item(OP_ADD,     0,  0, 1'b1); // highest-priority level, thread 0
    queue_item(OP_ADD,     5, 31, 1'b0); // append behind 31
    queue_item(OP_ADD,     0,  7, 1'b0); // already queued: ignored
    queue_item(OP_REMOVE,  7,  0, 1'b0); // not queued: ignored
    queue_item(OP_REMOVE, 31,  0, 1'b0); // wrong level: ignored
    queue_item(OP_SCHED,   0,  0, 1'b0); // gated, blocked by lock
    queue_item(OP_FORCE,   9,  3, 1'b1); // switch to thread 0
    queue_item(OP_FORCE,   0,  0, 1'b0); // same head, no switch
    queue_item(OP_ADD,    12, 31, 1'b0);
    queue_item(OP_ADD,    20, 31, 1'b1); // level 31: 31, 5, 12, 20
    queue_item(OP_REMOVE, 12, 31, 1'b0); // unlink from the middle
    queue_item(OP_REMOVE, 20, 31, 1'b0); // unlink the tail
    queue_item(OP_REMOVE, 31, 31, 1'b1); // unlink the head
    queue_item(OP_REMOVE,  5, 31, 1'b0); // last one, level goes empty
    queue_item(OP_REMOVE,  0,  0, 1'b0); // queue empty again
    queue_item(OP_FORCE,  17, 22, 1'b0); // empty: running thread stays
    wait_drained();

    // Unlocked and started: gated schedules can now run.
    apb_set(LOCKED_ADDR, 1'b0);
    apb_set(STARTED_ADDR, 1'b1);
    queue_item(OP_ADD,     3,  4, 1'b0);
    queue_item(OP_SCHED,   0,  0, 1'b1); // blocked by interrupt flag
    queue_item(OP_SCHED,   0,  0, 1'b0); // runs, switches to 3
    queue_item(OP_SCHED,   0,  0, 1'b0); // nothing pending: blocked
    queue_item(OP_FORCE,   0,  0, 1'b0);
    gen_random(250, 50, 25);             // mostly growing, reaches full queue
    wait_drained();

    // Locked again while started.
    apb_set(LOCKED_ADDR, 1'b1);
    gen_random(100, 30, 40);
    wait_drained();

    // Unlocked but not started.
    apb_set(LOCKED_ADDR, 1'b0);
    apb_set(STARTED_ADDR, 1'b0);
    gen_random(100, 40, 35);
    wait_drained();

    // Fully enabled again, mix leaning toward draining.
    apb_set(STARTED_ADDR, 1'b1);
    gen_random(250, 35, 40);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
